@@ rtl/core/spdc_pkg.sv @@
`default_nettype none

package spdc_pkg;

    // Fixed class layout: four strict-priority classes, 0 highest
    localparam int CLASS_COUNT = 4;
    localparam int CLASS_BITS  = 2;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_ID_BITS       = 16;
    localparam int DEF_DURATION_BITS = 16;

    // Input action codes
    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // Result outcome codes
    localparam logic OUT_ANSWERED = 1'b0;
    localparam logic OUT_DROPPED  = 1'b1;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/spdc_store.sv @@
`default_nettype none

module spdc_store #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/spdc_ctrl.sv @@
`default_nettype none

module spdc_ctrl #(
    parameter int QUEUE_DEPTH   = spdc_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS       = spdc_pkg::DEF_ID_BITS,
    parameter int DURATION_BITS = spdc_pkg::DEF_DURATION_BITS,
    parameter int PTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    parameter int ADDR_BITS     = spdc_pkg::CLASS_BITS + PTR_BITS,
    parameter int DATA_BITS     = ID_BITS + DURATION_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic                                action,
    input  wire logic [ID_BITS-1:0]                  caller_id,
    input  wire logic [spdc_pkg::CLASS_BITS-1:0]     priority_class,
    input  wire logic [DURATION_BITS-1:0]            call_duration,
    output logic                                     busy,
    output logic                                     done,
    output logic                                     outcome,
    output logic      [ID_BITS-1:0]                  served_id,
    output logic      [spdc_pkg::CLASS_BITS-1:0]     served_class,
    output logic                                     wr_en,
    output logic      [ADDR_BITS-1:0]                wr_addr,
    output logic      [DATA_BITS-1:0]                wr_data,
    output logic                                     rd_en,
    output logic      [ADDR_BITS-1:0]                rd_addr,
    input  wire logic [DATA_BITS-1:0]                rd_data
);

    localparam int CLASS_COUNT = spdc_pkg::CLASS_COUNT;
    localparam int CLASS_BITS  = spdc_pkg::CLASS_BITS;
    localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

    spdc_pkg::state_t state_reg, state_next;

    logic [PTR_BITS-1:0]      head_reg [CLASS_COUNT];
    logic [PTR_BITS-1:0]      head_next [CLASS_COUNT];
    logic [PTR_BITS-1:0]      tail_reg [CLASS_COUNT];
    logic [PTR_BITS-1:0]      tail_next [CLASS_COUNT];
    logic [FILL_BITS-1:0]     fill_reg [CLASS_COUNT];
    logic [FILL_BITS-1:0]     fill_next [CLASS_COUNT];
    logic [DURATION_BITS-1:0] busy_ticks_reg, busy_ticks_next;
    logic                     done_reg, done_next;
    logic                     outcome_reg, outcome_next;
    logic [ID_BITS-1:0]       served_id_reg, served_id_next;
    logic [CLASS_BITS-1:0]    served_class_reg, served_class_next;
    logic [CLASS_BITS-1:0]    pop_class_reg, pop_class_next;

    logic                     accept;
    logic                     queue_full;
    logic                     drop;
    logic                     pop;
    logic                     found;
    logic [CLASS_BITS-1:0]    sel_class;
    logic [ID_BITS-1:0]       rd_id;
    logic [DURATION_BITS-1:0] rd_dur;

    assign accept = start && (state_reg == spdc_pkg::ST_IDLE);
    assign busy   = (state_reg != spdc_pkg::ST_IDLE);

    // Pick the highest-priority (lowest-numbered) non-empty class
    always_comb
    begin
        found     = 1'b0;
        sel_class = '0;
        for (int i = CLASS_COUNT - 1; i >= 0; i--)
        begin
            if (fill_reg[i] != '0)
            begin
                found     = 1'b1;
                sel_class = CLASS_BITS'(i);
            end
        end
    end

    assign queue_full = (fill_reg[priority_class] == FILL_BITS'(QUEUE_DEPTH));
    assign drop       = accept && (action == spdc_pkg::ACT_ARRIVAL) && queue_full;
    assign pop        = accept && (action == spdc_pkg::ACT_TICK)
                        && (busy_ticks_reg == '0) && found;

    // Store request: append on arrival, fetch the chosen head on an answering tick
    assign wr_en   = accept && (action == spdc_pkg::ACT_ARRIVAL) && !queue_full;
    assign wr_addr = {priority_class, tail_reg[priority_class]};
    assign wr_data = {caller_id, call_duration};
    assign rd_en   = pop;
    assign rd_addr = {sel_class, head_reg[sel_class]};

    assign rd_id  = rd_data[DATA_BITS-1 -: ID_BITS];
    assign rd_dur = rd_data[DURATION_BITS-1:0];

    // Advance pointers, fill counts, busy count and state
    always_comb
    begin
        state_next      = state_reg;
        busy_ticks_next = busy_ticks_reg;
        pop_class_next  = pop_class_reg;
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            fill_next[i] = fill_reg[i];
        end

        case (state_reg)
            spdc_pkg::ST_IDLE:
            begin
                if (wr_en)
                begin
                    tail_next[priority_class] =
                        (tail_reg[priority_class] == PTR_BITS'(QUEUE_DEPTH - 1))
                        ? '0 : tail_reg[priority_class] + PTR_BITS'(1);
                    fill_next[priority_class] = fill_reg[priority_class] + FILL_BITS'(1);
                end
                if (pop)
                begin
                    head_next[sel_class] =
                        (head_reg[sel_class] == PTR_BITS'(QUEUE_DEPTH - 1))
                        ? '0 : head_reg[sel_class] + PTR_BITS'(1);
                    fill_next[sel_class] = fill_reg[sel_class] - FILL_BITS'(1);
                    pop_class_next       = sel_class;
                    state_next           = spdc_pkg::ST_READ;
                end
                else if (accept && (action == spdc_pkg::ACT_TICK)
                         && (busy_ticks_reg != '0))
                begin
                    busy_ticks_next = busy_ticks_reg - DURATION_BITS'(1);
                end
            end
            spdc_pkg::ST_READ:
            begin
                // Load the answered call's duration, already counting this tick
                busy_ticks_next = (rd_dur != '0) ? rd_dur - DURATION_BITS'(1) : '0;
                state_next      = spdc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spdc_pkg::ST_IDLE;
            end
        endcase
    end

    // Form the result item
    always_comb
    begin
        done_next         = 1'b0;
        outcome_next      = outcome_reg;
        served_id_next    = served_id_reg;
        served_class_next = served_class_reg;
        if (state_reg == spdc_pkg::ST_READ)
        begin
            done_next         = 1'b1;
            outcome_next      = spdc_pkg::OUT_ANSWERED;
            served_id_next    = rd_id;
            served_class_next = pop_class_reg;
        end
        else if (drop)
        begin
            done_next         = 1'b1;
            outcome_next      = spdc_pkg::OUT_DROPPED;
            served_id_next    = caller_id;
            served_class_next = priority_class;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spdc_pkg::ST_IDLE;
            busy_ticks_reg <= '0;
            done_reg       <= 1'b0;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            busy_ticks_reg <= busy_ticks_next;
            done_reg       <= done_next;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                fill_reg[i] <= fill_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pop_class_reg    <= pop_class_next;
        outcome_reg      <= outcome_next;
        served_id_reg    <= served_id_next;
        served_class_reg <= served_class_next;
    end

    assign done         = done_reg;
    assign outcome      = outcome_reg;
    assign served_id    = served_id_reg;
    assign served_class = served_class_reg;

endmodule

`default_nettype wire

@@ rtl/core/strict_priority_call_dispatcher_unit.sv @@
`default_nettype none

// Strict-priority call dispatcher: one server fed by four FIFO classes, class 0
// first. Issue an item by raising start while busy is low. An arrival (action 0)
// is taken without making busy go high; if its class queue is full, a drop
// result comes out in the next cycle. A tick (action 1) that finds the server
// idle and a call waiting reads the head entry from the call store: the store's
// registered read data and then the done register lie between the tick being
// taken and the answered call coming out. Any other tick is taken without making
// busy go high and gives no result. Each result is shown on done for exactly one
// cycle and cannot be held off by the receiver, so it must be captured when done is high.

module strict_priority_call_dispatcher_unit #(
    parameter int QUEUE_DEPTH   = spdc_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS       = spdc_pkg::DEF_ID_BITS,
    parameter int DURATION_BITS = spdc_pkg::DEF_DURATION_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            action,
    input  wire logic [ID_BITS-1:0]              caller_id,
    input  wire logic [spdc_pkg::CLASS_BITS-1:0] priority_class,
    input  wire logic [DURATION_BITS-1:0]        call_duration,
    output logic                                 done,
    output logic                                 outcome,
    output logic      [ID_BITS-1:0]              served_id,
    output logic      [spdc_pkg::CLASS_BITS-1:0] served_class
);

    localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ADDR_BITS = spdc_pkg::CLASS_BITS + PTR_BITS;
    localparam int DATA_BITS = ID_BITS + DURATION_BITS;

    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [DATA_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [DATA_BITS-1:0] rd_data;

    // Queue control and result formation
    spdc_ctrl #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ID_BITS       (ID_BITS),
        .DURATION_BITS (DURATION_BITS),
        .PTR_BITS      (PTR_BITS),
        .ADDR_BITS     (ADDR_BITS),
        .DATA_BITS     (DATA_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .action         (action),
        .caller_id      (caller_id),
        .priority_class (priority_class),
        .call_duration  (call_duration),
        .busy           (busy),
        .done           (done),
        .outcome        (outcome),
        .served_id      (served_id),
        .served_class   (served_class),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

    // Call store: one region per class
    spdc_store #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

@@ bench/strict_priority_call_dispatcher_unit_test.sv @@
`default_nettype none

module strict_priority_call_dispatcher_unit_test;

    localparam int CLASS_COUNT = spdc_pkg::CLASS_COUNT;
    localparam int CLASS_BITS  = spdc_pkg::CLASS_BITS;
    localparam int QDEPTH      = spdc_pkg::DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 360;
    localparam int SCRIPT_ROWS = 24;

    // How a scripted row is checked: by the dispatch model, by a typed-in result, or not at all
    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_ONE   = 2'd2
    } row_check_t;

    typedef struct packed {
        logic                  outcome;
        logic [15:0]           id;
        logic [CLASS_BITS-1:0] cls;
    } call_result_t;

    typedef struct packed {
        logic                  act;
        logic [15:0]           id;
        logic [CLASS_BITS-1:0] cls;
        logic [15:0]           dur;
        logic [16:0]           reps;
        row_check_t            chk;
        call_result_t          typed;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  action;
    logic [15:0]           caller_id;
    logic [CLASS_BITS-1:0] priority_class;
    logic [15:0]           call_duration;
    logic                  done;
    logic                  outcome;
    logic [15:0]           served_id;
    logic [CLASS_BITS-1:0] served_class;

    // Dispatch model state
    logic [15:0] slot_id   [CLASS_COUNT][QDEPTH];
    logic [15:0] slot_dur  [CLASS_COUNT][QDEPTH];
    int unsigned q_head    [CLASS_COUNT];
    int unsigned q_tail    [CLASS_COUNT];
    int unsigned q_fill    [CLASS_COUNT];
    logic [15:0] server_busy;

    call_result_t due_results[$];

    int err_count;
    int items_sent;
    int answered_count;
    int dropped_count;
    int cycle_count;

    // Directed script: empty tick, zero duration, full queue, long call,
    // arrival while busy, index wrap, priority order
    script_row_t script [SCRIPT_ROWS] = '{
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_ARRIVAL, 16'hFFFF, 2'd0, 16'h0000, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd1,  CHK_ONE,
            '{spdc_pkg::OUT_ANSWERED, 16'hFFFF, 2'd0}},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd3, 16'h0000, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_ARRIVAL, 16'h0001, 2'd3, 16'h0001, 17'd16, CHK_NONE,  '0},
        '{spdc_pkg::ACT_ARRIVAL, 16'hABCD, 2'd3, 16'hFFFF, 17'd1,  CHK_ONE,
            '{spdc_pkg::OUT_DROPPED, 16'hABCD, 2'd3}},
        '{spdc_pkg::ACT_ARRIVAL, 16'h1234, 2'd2, 16'h0003, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_ARRIVAL, 16'h0000, 2'd1, 16'h0040, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_TICK,    16'hFFFF, 2'd3, 16'hFFFF, 17'd1,  CHK_ONE,
            '{spdc_pkg::OUT_ANSWERED, 16'h0000, 2'd1}},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd63, CHK_NONE,  '0},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd1,  CHK_ONE,
            '{spdc_pkg::OUT_ANSWERED, 16'h1234, 2'd2}},
        '{spdc_pkg::ACT_ARRIVAL, 16'h8000, 2'd0, 16'h0000, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd1,  CHK_ONE,
            '{spdc_pkg::OUT_ANSWERED, 16'h8000, 2'd0}},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd1,  CHK_MODEL, '0},
        '{spdc_pkg::ACT_TICK,    16'h5555, 2'd1, 16'hAAAA, 17'd20, CHK_MODEL, '0},
        '{spdc_pkg::ACT_ARRIVAL, 16'h7FFE, 2'd3, 16'h0000, 17'd8,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd30, CHK_MODEL, '0},
        '{spdc_pkg::ACT_ARRIVAL, 16'h0F0F, 2'd3, 16'h0001, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_ARRIVAL, 16'hF0F0, 2'd2, 16'h0000, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_ARRIVAL, 16'h3C3C, 2'd1, 16'h0000, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_ARRIVAL, 16'hC3C3, 2'd0, 16'h0000, 17'd1,  CHK_NONE,  '0},
        '{spdc_pkg::ACT_TICK,    16'h0000, 2'd0, 16'h0000, 17'd6,  CHK_MODEL, '0}
    };

    strict_priority_call_dispatcher_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .caller_id      (caller_id),
        .priority_class (priority_class),
        .call_duration  (call_duration),
        .done           (done),
        .outcome        (outcome),
        .served_id      (served_id),
        .served_class   (served_class)
    );

    // Toggle the clock every half period
    always #4 clk = ~clk;

    // Advance the dispatch model by one item; return 1 when it gives a result
    function automatic bit dispatch_step(input logic act, input logic [15:0] id,
                                         input logic [CLASS_BITS-1:0] cls,
                                         input logic [15:0] dur,
                                         output call_result_t res);
        bit hit;
        int c;
        hit = 1'b0;
        res = '0;
        if (act == spdc_pkg::ACT_ARRIVAL)
        begin
            if (q_fill[cls] >= QDEPTH)
            begin
                res = '{spdc_pkg::OUT_DROPPED, id, cls};
                hit = 1'b1;
            end
            else
            begin
                slot_id[cls][q_tail[cls]]  = id;
                slot_dur[cls][q_tail[cls]] = dur;
                q_tail[cls] = (q_tail[cls] + 1) % QDEPTH;
                q_fill[cls]++;
            end
        end
        else
        begin
            // Pop the highest non-empty class only when the server is free
            if (server_busy == 16'd0)
            begin
                for (c = 0; c < CLASS_COUNT; c++)
                begin
                    if (!hit && q_fill[c] != 0)
                    begin
                        res = '{spdc_pkg::OUT_ANSWERED, slot_id[c][q_head[c]],
                                c[CLASS_BITS-1:0]};
                        server_busy = slot_dur[c][q_head[c]];
                        q_head[c] = (q_head[c] + 1) % QDEPTH;
                        q_fill[c]--;
                        hit = 1'b1;
                    end
                end
            end
            if (server_busy != 16'd0)
                server_busy--;
        end
        return hit;
    endfunction

    // Present one item, hold it until taken, then record what it should produce
    task automatic issue_item(input logic act, input logic [15:0] id,
                              input logic [CLASS_BITS-1:0] cls, input logic [15:0] dur,
                              input row_check_t chk, input call_result_t typed);
        call_result_t res;
        bit hit;
        start          <= 1'b1;
        action         <= act;
        caller_id      <= id;
        priority_class <= cls;
        call_duration  <= dur;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        hit = dispatch_step(act, id, cls, dur, res);
        items_sent++;
        if (hit && res.outcome == spdc_pkg::OUT_ANSWERED)
            answered_count++;
        if (hit && res.outcome == spdc_pkg::OUT_DROPPED)
            dropped_count++;
        case (chk)
            CHK_MODEL: if (hit) due_results.push_back(res);
            CHK_ONE:   due_results.push_back(typed);
            default:   ;
        endcase
    endtask

    // Hold start low while a random roll stays under gap_pct
    task automatic hold_off(input int gap_pct);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending until every expected result has come out
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // Random traffic in bursts that lean toward filling or draining the queues
    task automatic random_traffic(input int count, input int gap_pct);
        int k;
        int tick_pct;
        int roll;
        logic [CLASS_BITS-1:0] hot_cls;
        logic [CLASS_BITS-1:0] cls;
        logic [15:0] dur;
        tick_pct = 50;
        hot_cls  = '0;
        for (k = 0; k < count; k++)
        begin
            if (k % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       tick_pct = 15;
                    1:       tick_pct = 50;
                    default: tick_pct = 85;
                endcase
                hot_cls = CLASS_BITS'($urandom_range(CLASS_COUNT - 1));
            end
            cls  = ($urandom_range(1) == 0) ? hot_cls
                                            : CLASS_BITS'($urandom_range(CLASS_COUNT - 1));
            roll = $urandom_range(99);
            if (roll < 60)
                dur = 16'($urandom_range(2));
            else if (roll < 95)
                dur = 16'($urandom_range(12, 3));
            else
                dur = 16'($urandom_range(60, 13));
            issue_item(($urandom_range(99) < tick_pct) ? spdc_pkg::ACT_TICK
                                                        : spdc_pkg::ACT_ARRIVAL,
                       16'($urandom_range(16'hFFFF)), cls, dur, CHK_MODEL, '0);
            hold_off(gap_pct);
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        call_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none got %0d/%h/%0d",
                         $time, outcome, served_id, served_class);
                err_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (outcome !== want.outcome)
                begin
                    $display("%0t: outcome mismatch expected %0d got %0d",
                             $time, want.outcome, outcome);
                    err_count++;
                end
                if (served_id !== want.id)
                begin
                    $display("%0t: served_id mismatch expected %h got %h",
                             $time, want.id, served_id);
                    err_count++;
                end
                if (served_class !== want.cls)
                begin
                    $display("%0t: served_class mismatch expected %0d got %0d",
                             $time, want.cls, served_class);
                    err_count++;
                end
            end
        end
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycle_count, due_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int i;
        int r;
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        action         = spdc_pkg::ACT_ARRIVAL;
        caller_id      = '0;
        priority_class = '0;
        call_duration  = '0;
        err_count      = 0;
        items_sent     = 0;
        answered_count = 0;
        dropped_count  = 0;
        cycle_count    = 0;
        server_busy    = '0;
        for (i = 0; i < CLASS_COUNT; i++)
        begin
            q_head[i] = 0;
            q_tail[i] = 0;
            q_fill[i] = 0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed script
        for (i = 0; i < SCRIPT_ROWS; i++)
        begin
            for (r = 0; r < script[i].reps; r++)
            begin
                issue_item(script[i].act, script[i].id + r[15:0], script[i].cls,
                           script[i].dur, script[i].chk, script[i].typed);
                hold_off(9);
            end
        end
        drain_results();

        // Random phases: light sender gaps, heavy gaps, then back to back
        random_traffic(PHASE_ITEMS, 9);
        drain_results();
        random_traffic(PHASE_ITEMS, 83);
        drain_results();
        random_traffic(PHASE_ITEMS, 0);
        drain_results();

        repeat (8) @(posedge clk);

        $display("Covered %0d items: %0d calls answered, %0d arrivals dropped on full queues,",
                 items_sent, answered_count, dropped_count);
        $display("including a long call, queue index wrap and all four classes.");
        if (err_count == 0 && due_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
